// File: design/bsd_pkg.sv
// bsd_pkg: shared constants and result type for the bmp stream pixel decoder
// depends on nothing
`timescale 1ns / 1ps
package bsd_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int IDX_W = 24;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;
    localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    localparam logic [5:0] OFF_SIG = 6'd1;
    localparam logic [5:0] OFF_RSVD = 6'd9;
    localparam logic [5:0] OFF_HSIZE = 6'd17;
    localparam logic [5:0] OFF_WIDTH = 6'd21;
    localparam logic [5:0] OFF_HEIGHT = 6'd25;
    localparam logic [5:0] OFF_PLANES = 6'd27;
    localparam logic [5:0] OFF_BITS = 6'd29;
    localparam logic [5:0] OFF_COMPR = 6'd33;
    localparam logic [5:0] OFF_LAST = 6'd53;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [3:0] ERR_NONE = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE = 4'd1;
    localparam logic [3:0] ERR_RESERVED = 4'd2;
    localparam logic [3:0] ERR_HDR_SIZE = 4'd3;
    localparam logic [3:0] ERR_PLANES = 4'd4;
    localparam logic [3:0] ERR_COMPRESSION = 4'd5;
    localparam logic [3:0] ERR_BIT_COUNT = 4'd6;
    localparam logic [3:0] ERR_DIMENSION = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED = 4'd8;

    typedef struct packed {
        logic result_kind;
        logic [31:0] pixel_value;
        logic [IDX_W-1:0] pixel_index;
        logic last_pixel;
        logic [3:0] error_code;
    } result_t;

    typedef struct packed {
        logic push;
        result_t data;
    } push_t;

endpackage

// File: design/bsd_if.sv
// bsd_in_if and bsd_out_if: valid/ready channels of the decoder
// depends on nothing
`timescale 1ns / 1ps
interface bsd_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic frame_start;
    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface bsd_out_if;
    logic valid;
    logic ready;
    logic result_kind;
    logic [31:0] pixel_value;
    logic [23:0] pixel_index;
    logic last_pixel;
    logic [3:0] error_code;
    modport source (output valid, output result_kind, output pixel_value,
        output pixel_index, output last_pixel, output error_code, input ready);
    modport sink (input valid, input result_kind, input pixel_value,
        input pixel_index, input last_pixel, input error_code, output ready);
endinterface

// File: design/bmp_stream_pixel_decoder_top.sv
// bmp_stream_pixel_decoder_top: 24/32 bit uncompressed bmp byte stream decoder
// depends on bsd_pkg, bsd_if, bsd_front, bsd_queue
//
//   channel   dir  payload
//   in_ch     in   data_byte[7:0], frame_start
//   out_ch    out  result_kind, pixel_value[31:0], pixel_index[23:0],
//                  last_pixel, error_code[3:0]
//
// one byte per cycle while the result queue is not full; each result is written
// into the result queue before it reaches out_ch; the front parser holds all
// decode state; the row base multiply is done once per row and registered
// in_ch stalls only when the result queue is full
// reset: asynchronous, active low, decoder idle until frame_start
`timescale 1ns / 1ps
module bmp_stream_pixel_decoder_top #(
    parameter int MAX_DIM = bsd_pkg::MAX_DIM_DEF,
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    bsd_in_if.sink in_ch,
    bsd_out_if.source out_ch
);
    import bsd_pkg::*;

    push_t push;
    result_t head;
    logic not_full;

    assign in_ch.ready = not_full;

    bsd_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(in_ch.valid && not_full),
        .data_byte(in_ch.data_byte),
        .frame_start(in_ch.frame_start),
        .push(push)
    );

    bsd_queue #(.DEPTH(DEPTH)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .not_full(not_full),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .out_data(head)
    );

    assign out_ch.result_kind = head.result_kind;
    assign out_ch.pixel_value = head.pixel_value;
    assign out_ch.pixel_index = head.pixel_index;
    assign out_ch.last_pixel = head.last_pixel;
    assign out_ch.error_code = head.error_code;

endmodule

// File: design/bsd_front.sv
// bsd_front: header parser and pixel assembler, one byte per cycle while in_fire is high
// depends on bsd_pkg
`timescale 1ns / 1ps
module bsd_front #(
    parameter int MAX_DIM = bsd_pkg::MAX_DIM_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic [7:0] data_byte,
    input  logic frame_start,
    output bsd_pkg::push_t push
);
    import bsd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_PADDING,
        PH_DONE
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [5:0] off_reg, off_next;
    logic [31:0] shift_reg, shift_next;
    logic [DIM_W-1:0] width_reg, width_next, height_reg, height_next;
    logic mir_col_reg, mir_col_next, mir_row_reg, mir_row_next;
    logic [2:0] bpp_reg, bpp_next;
    logic [DIM_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [1:0] bip_reg, bip_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0] pad_reg, pad_next;
    logic [IDX_W-1:0] base_reg, base_next;

    function automatic logic [DIM_W:0] dim_mag(input logic [31:0] v);
        logic [31:0] mag;
        mag = v[31] ? (32'd0 - v) : v;
        if (mag == 32'd0 || mag > 32'(MAX_DIM)) return '0;
        return {v[31], mag[DIM_W-1:0]};
    endfunction

    logic [DIM_W:0] dm;
    logic [DIM_W-1:0] new_row, y_row, x_col;
    logic [2*DIM_W-1:0] prod;
    logic [1:0] pad_calc;
    logic is_last, row_end, do_begin;
    phase_t ph;
    logic [5:0] off;
    logic [31:0] shv;

    always_comb
    begin
        phase_next = phase_reg;
        off_next = off_reg;
        shift_next = shift_reg;
        width_next = width_reg;
        height_next = height_reg;
        mir_col_next = mir_col_reg;
        mir_row_next = mir_row_reg;
        bpp_next = bpp_reg;
        col_next = col_reg;
        row_next = row_reg;
        bip_next = bip_reg;
        acc_next = acc_reg;
        pad_next = pad_reg;
        base_next = base_reg;
        push = '0;
        do_begin = 1'b0;
        new_row = '0;
        dm = '0;
        is_last = 1'b0;
        row_end = 1'b0;
        pad_calc = 2'(2'd0 - 2'(width_reg[1:0] * bpp_reg[1:0]));
        x_col = mir_col_reg ? (width_reg - 1'b1 - col_reg) : col_reg;
        ph = phase_reg;
        off = off_reg;
        shv = shift_reg;
        if (in_fire)
        begin
            if (frame_start)
            begin
                if (phase_reg == PH_HEADER || phase_reg == PH_PIXELS
                    || phase_reg == PH_PADDING)
                begin
                    push.push = 1'b1;
                    push.data.result_kind = KIND_ERROR;
                    push.data.error_code = ERR_TRUNCATED;
                end
                ph = PH_HEADER;
                off = '0;
                shv = '0;
            end
            phase_next = ph;
            unique case (ph)
                PH_HEADER:
                begin
                    shv = {data_byte, shv[31:8]};
                    shift_next = shv;
                    off_next = off + 1'b1;
                    push.data.result_kind = KIND_ERROR;
                    case (off)
                        OFF_SIG:
                            if (shv[31:16] != {SIG_M, SIG_B})
                                push.data.error_code = ERR_SIGNATURE;
                        OFF_RSVD:
                            if (shv != 32'd0) push.data.error_code = ERR_RESERVED;
                        OFF_HSIZE:
                            if (shv != INFO_HDR_SIZE) push.data.error_code = ERR_HDR_SIZE;
                        OFF_WIDTH:
                        begin
                            dm = dim_mag(shv);
                            width_next = dm[DIM_W-1:0];
                            mir_col_next = shv[31];
                        end
                        OFF_HEIGHT:
                        begin
                            dm = dim_mag(shv);
                            height_next = dm[DIM_W-1:0];
                            mir_row_next = shv[31];
                        end
                        OFF_PLANES:
                            if (shv[31:16] != 16'd1) push.data.error_code = ERR_PLANES;
                        OFF_BITS:
                            bpp_next = (shv[31:16] == BPP_24) ? 3'd3
                                     : (shv[31:16] == BPP_32) ? 3'd4 : 3'd0;
                        OFF_COMPR:
                        begin
                            if (shv != 32'd0) push.data.error_code = ERR_COMPRESSION;
                            else if (bpp_reg == 3'd0) push.data.error_code = ERR_BIT_COUNT;
                            else if (width_reg == '0 || height_reg == '0)
                                push.data.error_code = ERR_DIMENSION;
                        end
                        OFF_LAST:
                        begin
                            bip_next = '0;
                            acc_next = '0;
                            pad_next = '0;
                            do_begin = 1'b1;
                            new_row = '0;
                            phase_next = PH_PIXELS;
                        end
                        default: ;
                    endcase
                    if (push.data.error_code != ERR_NONE)
                    begin
                        if (push.push)
                        begin
                            push.data.error_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            push.push = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_PIXELS:
                begin
                    acc_next = acc_reg | (32'(data_byte) << {bip_reg, 3'b000});
                    if ({1'b0, bip_reg} + 3'd1 < bpp_reg)
                    begin
                        bip_next = bip_reg + 1'b1;
                    end
                    else
                    begin
                        is_last = ({1'b0, col_reg} + 1'b1 >= {1'b0, width_reg})
                               && ({1'b0, row_reg} + 1'b1 >= {1'b0, height_reg});
                        push.push = 1'b1;
                        push.data.result_kind = KIND_PIXEL;
                        push.data.pixel_value = acc_next;
                        push.data.pixel_index = base_reg + IDX_W'(x_col);
                        push.data.last_pixel = is_last;
                        push.data.error_code = ERR_NONE;
                        bip_next = '0;
                        acc_next = '0;
                        row_end = ({1'b0, col_reg} + 1'b1 >= {1'b0, width_reg});
                        col_next = col_reg + 1'b1;
                        if (row_end)
                        begin
                            if (is_last)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (pad_calc != 2'd0)
                            begin
                                pad_next = pad_calc;
                                phase_next = PH_PADDING;
                            end
                            else
                            begin
                                do_begin = 1'b1;
                                new_row = row_reg + 1'b1;
                            end
                        end
                    end
                end
                PH_PADDING:
                begin
                    pad_next = pad_reg - 1'b1;
                    if (pad_next == 2'd0)
                    begin
                        phase_next = PH_PIXELS;
                        do_begin = 1'b1;
                        new_row = row_reg + 1'b1;
                    end
                end
                PH_IDLE, PH_DONE: ;
                default: ;
            endcase
        end
        y_row = mir_row_next ? (height_next - 1'b1 - new_row) : new_row;
        prod = y_row * width_next;
        if (do_begin)
        begin
            row_next = new_row;
            col_next = '0;
            base_next = IDX_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            off_reg <= '0;
            shift_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            mir_col_reg <= 1'b0;
            mir_row_reg <= 1'b0;
            bpp_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            bip_reg <= '0;
            acc_reg <= '0;
            pad_reg <= '0;
            base_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg <= off_next;
            shift_reg <= shift_next;
            width_reg <= width_next;
            height_reg <= height_next;
            mir_col_reg <= mir_col_next;
            mir_row_reg <= mir_row_next;
            bpp_reg <= bpp_next;
            col_reg <= col_next;
            row_reg <= row_next;
            bip_reg <= bip_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
            base_reg <= base_next;
        end
    end

endmodule

// File: design/bsd_queue.sv
// bsd_queue: result queue that feeds the output channel
// depends on bsd_pkg
`timescale 1ns / 1ps
module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  bsd_pkg::push_t push,
    output logic not_full,
    output logic out_valid,
    input  logic out_ready,
    output bsd_pkg::result_t out_data
);
    import bsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0] cnt_reg, cnt_next;
    logic pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign not_full = cnt_reg != (PTR_W + 1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data = mem[rd_reg];
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_next = push.push ? ptr_inc(wr_reg) : wr_reg;
        rd_next = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + (PTR_W + 1)'(push.push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: bench/testbench.sv
// testbench: byte stream stimulus and result scoreboard for the bmp stream pixel decoder
// depends on bsd_pkg, bsd_if and bmp_stream_pixel_decoder_top
`timescale 1ns / 1ps
class bmp_scoreboard;
    bsd_pkg::result_t pending[$];
    int failures;
    bit [2:0] phase;
    bit [5:0] hdr_off;
    bit [31:0] shreg;
    bit [31:0] width, height;
    bit flip_x, flip_y;
    bit [2:0] bpp;
    bit [31:0] col, row;
    bit [1:0] byte_pos;
    bit [31:0] acc;
    bit [1:0] pad;
    bit [23:0] row_base;

    localparam bit [2:0] P_IDLE = 0, P_HDR = 1, P_PIX = 2, P_PAD = 3, P_DONE = 4;

    function new();
        failures = 0;
        phase = P_IDLE;
        hdr_off = 0;
        shreg = 0;
        width = 0;
        height = 0;
        flip_x = 0;
        flip_y = 0;
        bpp = 0;
        col = 0;
        row = 0;
        byte_pos = 0;
        acc = 0;
        pad = 0;
        row_base = 0;
    endfunction

    function bit [31:0] magnitude(bit [31:0] v);
        bit [31:0] m;
        m = v[31] ? -v : v;
        if (m == 0 || m > bsd_pkg::MAX_DIM_DEF)
            return 0;
        return m;
    endfunction

    function void start_row(bit [31:0] r);
        bit [31:0] y;
        y = flip_y ? height - 1 - r : r;
        row = r;
        col = 0;
        row_base = 24'(y * width);
    endfunction

    function void push_result(bit kind, bit [31:0] val, bit [23:0] idx, bit last,
                              bit [3:0] code);
        bsd_pkg::result_t r;
        r.result_kind = kind;
        r.pixel_value = val;
        r.pixel_index = idx;
        r.last_pixel = last;
        r.error_code = code;
        pending.push_back(r);
    endfunction

    function bit [3:0] header_check(bit [7:0] b);
        bit [5:0] off;
        off = hdr_off;
        shreg = {b, shreg[31:8]};
        hdr_off = off + 1;
        case (off)
            bsd_pkg::OFF_SIG:
                if (shreg[31:16] != {bsd_pkg::SIG_M, bsd_pkg::SIG_B})
                    return bsd_pkg::ERR_SIGNATURE;
            bsd_pkg::OFF_RSVD:
                if (shreg != 0)
                    return bsd_pkg::ERR_RESERVED;
            bsd_pkg::OFF_HSIZE:
                if (shreg != bsd_pkg::INFO_HDR_SIZE)
                    return bsd_pkg::ERR_HDR_SIZE;
            bsd_pkg::OFF_WIDTH:
            begin
                width = magnitude(shreg);
                flip_x = shreg[31];
            end
            bsd_pkg::OFF_HEIGHT:
            begin
                height = magnitude(shreg);
                flip_y = shreg[31];
            end
            bsd_pkg::OFF_PLANES:
                if (shreg[31:16] != 1)
                    return bsd_pkg::ERR_PLANES;
            bsd_pkg::OFF_BITS:
                bpp = shreg[31:16] == bsd_pkg::BPP_24 ? 3 :
                      shreg[31:16] == bsd_pkg::BPP_32 ? 4 : 0;
            bsd_pkg::OFF_COMPR:
            begin
                if (shreg != 0)
                    return bsd_pkg::ERR_COMPRESSION;
                if (bpp == 0)
                    return bsd_pkg::ERR_BIT_COUNT;
                if (width == 0 || height == 0)
                    return bsd_pkg::ERR_DIMENSION;
            end
            bsd_pkg::OFF_LAST:
            begin
                byte_pos = 0;
                acc = 0;
                pad = 0;
                start_row(0);
                phase = P_PIX;
            end
            default:
                ;
        endcase
        return bsd_pkg::ERR_NONE;
    endfunction

    function void note_transfer(bit [7:0] b, bit fs);
        bit [3:0] code;
        bit made;
        bit [31:0] x;
        bit last;
        made = 0;
        if (fs)
        begin
            if (phase == P_HDR || phase == P_PIX || phase == P_PAD)
            begin
                push_result(bsd_pkg::KIND_ERROR, 0, 0, 0, bsd_pkg::ERR_TRUNCATED);
                made = 1;
            end
            phase = P_HDR;
            hdr_off = 0;
            shreg = 0;
        end
        case (phase)
            P_HDR:
            begin
                code = header_check(b);
                if (code != bsd_pkg::ERR_NONE && !made)
                begin
                    push_result(bsd_pkg::KIND_ERROR, 0, 0, 0, code);
                    phase = P_DONE;
                end
            end
            P_PIX:
            begin
                acc |= 32'(b) << (8 * byte_pos);
                if (32'(byte_pos) + 1 < 32'(bpp))
                    byte_pos++;
                else
                begin
                    x = flip_x ? width - 1 - col : col;
                    last = col + 1 >= width && row + 1 >= height;
                    push_result(bsd_pkg::KIND_PIXEL, acc, 24'(row_base + x), last,
                                bsd_pkg::ERR_NONE);
                    byte_pos = 0;
                    acc = 0;
                    col++;
                    if (col >= width)
                    begin
                        if (last)
                            phase = P_DONE;
                        else
                        begin
                            pad = 2'(0 - width * bpp);
                            if (pad != 0)
                                phase = P_PAD;
                            else
                                start_row(row + 1);
                        end
                    end
                end
            end
            P_PAD:
            begin
                pad--;
                if (pad == 0)
                begin
                    phase = P_PIX;
                    start_row(row + 1);
                end
            end
            default:
                ;
        endcase
    endfunction

    function void check_result(bsd_pkg::result_t got);
        bsd_pkg::result_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            failures++;
            return;
        end
        want = pending.pop_front();
        if (got.result_kind != want.result_kind)
        begin
            $display("%0t: result_kind expected %0d actual %0d", $time,
                     want.result_kind, got.result_kind);
            failures++;
        end
        if (got.pixel_value != want.pixel_value)
        begin
            $display("%0t: pixel_value expected %h actual %h", $time,
                     want.pixel_value, got.pixel_value);
            failures++;
        end
        if (got.pixel_index != want.pixel_index)
        begin
            $display("%0t: pixel_index expected %0d actual %0d", $time,
                     want.pixel_index, got.pixel_index);
            failures++;
        end
        if (got.last_pixel != want.last_pixel)
        begin
            $display("%0t: last_pixel expected %0d actual %0d", $time,
                     want.last_pixel, got.last_pixel);
            failures++;
        end
        if (got.error_code != want.error_code)
        begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, got.error_code);
            failures++;
        end
    endfunction
endclass

module testbench;
    logic clk;
    logic rst_n;
    int send_idle;
    int recv_idle;
    int sent;
    byte unsigned file_bytes[$];

    bsd_in_if in_ch();
    bsd_out_if out_ch();
    bmp_scoreboard board;

    bmp_stream_pixel_decoder_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: ready changes on the falling edge, results sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.result_kind, out_ch.pixel_value,
                                out_ch.pixel_index, out_ch.last_pixel,
                                out_ch.error_code});
    end

    always @(negedge clk)
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);

    task automatic send_byte(input bit [7:0] b, input bit fs);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.frame_start <= fs;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_transfer(b, fs);
        sent++;
        @(negedge clk);
    endtask

    task automatic add_word(input bit [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endtask

    // header and pixel bytes; bad selects which field gets corrupted (0 none)
    task automatic build_file(input int w, input int h, input int bits, input int bad,
                              input bit truncate);
        int bpp;
        int pad;
        int stop;
        file_bytes.delete();
        add_word(bad == 1 ? 16'h4D43 : 16'h4D42, 2);
        add_word($urandom, 4);
        add_word(bad == 2 ? 32'h0100 : 0, 4);
        add_word($urandom, 4);
        add_word(bad == 3 ? 12 : 40, 4);
        add_word(w, 4);
        add_word(h, 4);
        add_word(bad == 4 ? 2 : 1, 2);
        add_word(bits, 2);
        add_word(bad == 5 ? 1 : 0, 4);
        for (int i = 0; i < 20; i++)
            file_bytes.push_back($urandom);
        bpp = bits / 8;
        w = w < 0 ? -w : w;
        h = h < 0 ? -h : h;
        pad = (4 - (w * bpp) % 4) % 4;
        if (bad == 0 && (bits == 24 || bits == 32) && w > 0 && h > 0 && w <= 16 && h <= 16)
            for (int i = 0; i < h * (w * bpp + pad); i++)
                file_bytes.push_back($urandom);
        // bytes after a failed header check are ignored, so the file stops there
        stop = file_bytes.size();
        if (bad == 1)
            stop = int'(bsd_pkg::OFF_SIG) + 1;
        else if (bad == 2)
            stop = int'(bsd_pkg::OFF_RSVD) + 1;
        else if (bad == 3)
            stop = int'(bsd_pkg::OFF_HSIZE) + 1;
        else if (bad == 4)
            stop = int'(bsd_pkg::OFF_PLANES) + 1;
        else if (bad == 5 || !(bits == 24 || bits == 32) || w <= 0 || h <= 0
                 || w > bsd_pkg::MAX_DIM_DEF || h > bsd_pkg::MAX_DIM_DEF)
            stop = int'(bsd_pkg::OFF_COMPR) + 1;
        while (file_bytes.size() > stop)
            void'(file_bytes.pop_back());
        if (truncate && file_bytes.size() > 2)
        begin
            stop = $urandom_range(file_bytes.size() - 1, 1);
            while (file_bytes.size() > stop)
                void'(file_bytes.pop_back());
        end
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
    endtask

    task automatic run_random_files(input int count);
        int kind;
        int w, h;
        for (int f = 0; f < count; f++)
        begin
            kind = $urandom_range(19);
            w = $urandom_range(5, 1);
            h = $urandom_range(4, 1);
            if ($urandom_range(1))
                w = -w;
            if ($urandom_range(1))
                h = -h;
            if (kind < 13)
                build_file(w, h, $urandom_range(1) ? 24 : 32, 0, kind == 12);
            else if (kind < 18)
                build_file(w, h, $urandom_range(1) ? 24 : 32, $urandom_range(5, 1), 0);
            else
            begin
                file_bytes.delete();
                for (int i = 0; i < $urandom_range(60, 1); i++)
                    file_bytes.push_back($urandom);
            end
            send_file();
            // stray bytes after a finished or rejected frame are ignored
            if ($urandom_range(3) == 0)
                send_byte($urandom, 1'b0);
        end
    endtask

    initial
    begin
        int limit;
        board = new();
        sent = 0;
        send_idle = 22;
        recv_idle = 66;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.frame_start = 1'b0;
        out_ch.ready = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray byte while idle, then directed headers and errors
        send_byte(8'hFF, 1'b0);
        for (int b = 1; b <= 5; b++)
        begin
            build_file(2, 2, 24, b, 0);
            send_file();
        end
        build_file(2, 2, 16, 0, 0);
        send_file();
        build_file(0, 2, 24, 0, 0);
        send_file();
        build_file(4097, 1, 32, 0, 0);
        send_file();
        build_file(32'h80000000, 1, 32, 0, 0);
        send_file();
        build_file(1, 4096, 24, 0, 1);
        send_file();
        build_file(4096, -4096, 32, 0, 1);
        send_file();
        build_file(-3, -2, 24, 0, 0);
        send_file();
        build_file(3, 2, 32, 0, 0);
        send_file();
        build_file(-1, 3, 32, 0, 1);
        send_file();

        // hold off until everything drains
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);

        run_random_files(1);
        send_idle = 66;
        recv_idle = 22;
        run_random_files(1);
        send_idle = 0;
        recv_idle = 0;
        run_random_files(1);
        in_ch.valid <= 1'b0;

        limit = 0;
        while (board.pending.size() != 0 && limit < 100000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (20)
            @(posedge clk);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
